// ===== rtl/core/ssl_pkg.sv =====
`timescale 1ns / 1ps

package ssl_pkg;

    localparam int OFF_W   = 16;
    localparam int LEN_W   = 17;
    localparam int TOTAL_W = 24;
    localparam int ERA_W   = 8;
    localparam int ENTRY_W = OFF_W + LEN_W;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_SCAN_RD  = 8'b00000010,
        ST_SCAN_EV  = 8'b00000100,
        ST_INS      = 8'b00001000,
        ST_SHIFT_RD = 8'b00010000,
        ST_SHIFT_WR = 8'b00100000,
        ST_PUT      = 8'b01000000,
        ST_DONE     = 8'b10000000
    } state_t;

    typedef enum logic [2:0] {
        OUT_SAME   = 3'd0,
        OUT_BEFORE = 3'd1,
        OUT_APPEND = 3'd2,
        OUT_MERGE  = 3'd3,
        OUT_IGNORE = 3'd4
    } outcome_t;

    typedef struct packed {
        logic               same;
        logic               right_of;
        logic               left;
        logic [OFF_W-1:0]   noff;
        logic [LEN_W-1:0]   nlen;
        logic [TOTAL_W-1:0] total;
        logic               ovf;
    } alu_res_t;

endpackage

// ===== rtl/core/sorted_segment_list_insert_top.sv =====
`timescale 1ns / 1ps
// Scanned and shifted entries together never exceed N + 1, N being the segments held; each
// entry is read through the single read port of the segment RAM. One request is taken at
// a time: s_ready is high only while idle. Reset (aresetn, synchronous, active low) clears
// count, total and era; the RAM is not cleared.

module sorted_segment_list_insert_top #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_seg_offset,
    input  logic [15:0] s_seg_length,
    input  logic [7:0]  s_era,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [4:0]  m_seg_count,
    output logic [23:0] m_total_length,
    output logic        m_overflow
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    ssl_pkg::state_t   state_reg, state_next;
    ssl_pkg::outcome_t outcome_reg, outcome_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     k_prev;
    logic [23:0]       total_reg, total_next;
    logic [7:0]        era_reg, era_next;
    logic              era_seen_reg, era_seen_next;
    logic [15:0]       off_reg, off_next;
    logic [15:0]       len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_outcome_reg, m_outcome_next;
    logic [4:0]        m_count_reg, m_count_next;
    logic [23:0]       m_total_reg, m_total_next;
    logic              m_ovf_reg, m_ovf_next;
    logic [31:0]       count_wide;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [ssl_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [ssl_pkg::ENTRY_W-1:0]  ram_rdata;
    ssl_pkg::alu_res_t            alu_res;

    ssl_ram #(
        .WIDTH (ssl_pkg::ENTRY_W),
        .DEPTH (MAX_SEGMENTS),
        .ADDR_W(AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ssl_alu u_alu (
        .merge_sel(state_reg == ssl_pkg::ST_SCAN_EV),
        .off      (off_reg),
        .len      (len_reg),
        .so       (ram_rdata[ssl_pkg::ENTRY_W-1:ssl_pkg::LEN_W]),
        .sl       (ram_rdata[ssl_pkg::LEN_W-1:0]),
        .total    (total_reg),
        .res      (alu_res)
    );

    assign k_prev     = k_reg - 1'b1;
    assign count_wide = 32'(count_reg);

    always_comb begin
        state_next     = state_reg;
        outcome_next   = outcome_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        era_next       = era_reg;
        era_seen_next  = era_seen_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        m_valid_next   = m_valid_reg;
        m_outcome_next = m_outcome_reg;
        m_count_next   = m_count_reg;
        m_total_next   = m_total_reg;
        m_ovf_next     = m_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[AW-1:0];
        ram_raddr      = pos_reg[AW-1:0];
        ram_wdata      = {alu_res.noff, alu_res.nlen};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ssl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    off_next = s_seg_offset;
                    len_next = s_seg_length;
                    // A new era, or the first request after reset, starts from an empty list.
                    if (!era_seen_reg || s_era != era_reg) begin
                        count_next = '0;
                        total_next = '0;
                    end
                    era_seen_next = 1'b1;
                    era_next      = s_era;
                    pos_next      = '0;
                    state_next    = ssl_pkg::ST_SCAN_RD;
                end
            end
            ssl_pkg::ST_SCAN_RD: begin
                if (pos_reg == count_reg) begin
                    state_next = ssl_pkg::ST_INS;
                end else begin
                    state_next = ssl_pkg::ST_SCAN_EV;
                end
            end
            ssl_pkg::ST_SCAN_EV: begin
                if (alu_res.same) begin
                    outcome_next = ssl_pkg::OUT_SAME;
                    ovf_next     = 1'b0;
                    state_next   = ssl_pkg::ST_DONE;
                end else if (alu_res.right_of) begin
                    state_next = ssl_pkg::ST_INS;
                end else if (alu_res.left) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ssl_pkg::ST_SCAN_RD;
                end else begin
                    ram_we       = 1'b1;
                    total_next   = alu_res.total;
                    ovf_next     = alu_res.ovf;
                    outcome_next = ssl_pkg::OUT_MERGE;
                    state_next   = ssl_pkg::ST_DONE;
                end
            end
            ssl_pkg::ST_INS: begin
                if (len_reg == '0) begin
                    outcome_next = ssl_pkg::OUT_IGNORE;
                    ovf_next     = 1'b0;
                    state_next   = ssl_pkg::ST_DONE;
                end else if (count_reg == CW'(MAX_SEGMENTS)) begin
                    outcome_next = ssl_pkg::OUT_IGNORE;
                    ovf_next     = 1'b1;
                    state_next   = ssl_pkg::ST_DONE;
                end else begin
                    k_next     = count_reg;
                    state_next = ssl_pkg::ST_SHIFT_RD;
                end
            end
            ssl_pkg::ST_SHIFT_RD: begin
                ram_raddr = k_prev[AW-1:0];
                if (k_reg == pos_reg) begin
                    state_next = ssl_pkg::ST_PUT;
                end else begin
                    state_next = ssl_pkg::ST_SHIFT_WR;
                end
            end
            ssl_pkg::ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                k_next     = k_prev;
                state_next = ssl_pkg::ST_SHIFT_RD;
            end
            ssl_pkg::ST_PUT: begin
                ram_we     = 1'b1;
                ram_wdata  = {off_reg, 1'b0, len_reg};
                if (pos_reg == count_reg) begin
                    outcome_next = ssl_pkg::OUT_APPEND;
                end else begin
                    outcome_next = ssl_pkg::OUT_BEFORE;
                end
                count_next = count_reg + 1'b1;
                total_next = alu_res.total;
                ovf_next   = alu_res.ovf;
                state_next = ssl_pkg::ST_DONE;
            end
            ssl_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_outcome_next = outcome_reg;
                    m_count_next   = count_wide[4:0];
                    m_total_next   = total_reg;
                    m_ovf_next     = ovf_reg;
                    state_next     = ssl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssl_pkg::ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            era_reg      <= '0;
            era_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            era_reg      <= era_next;
            era_seen_reg <= era_seen_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        outcome_reg   <= outcome_next;
        pos_reg       <= pos_next;
        k_reg         <= k_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        ovf_reg       <= ovf_next;
        m_outcome_reg <= m_outcome_next;
        m_count_reg   <= m_count_next;
        m_total_reg   <= m_total_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign s_ready        = (state_reg == ssl_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_outcome      = m_outcome_reg;
    assign m_seg_count    = m_count_reg;
    assign m_total_length = m_total_reg;
    assign m_overflow     = m_ovf_reg;

endmodule

// ===== rtl/core/ssl_ram.sv =====
`timescale 1ns / 1ps

module ssl_ram #(
    parameter int WIDTH  = 33,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ssl_alu.sv =====
`timescale 1ns / 1ps

module ssl_alu (
    input  logic                          merge_sel,
    input  logic [ssl_pkg::OFF_W-1:0]     off,
    input  logic [15:0]                   len,
    input  logic [ssl_pkg::OFF_W-1:0]     so,
    input  logic [ssl_pkg::LEN_W-1:0]     sl,
    input  logic [ssl_pkg::TOTAL_W-1:0]   total,
    output ssl_pkg::alu_res_t             res
);

    logic [16:0] seg_end;
    logic [17:0] st_end;
    logic [17:0] new_end;
    logic [15:0] new_off;
    logic [17:0] span;
    logic [25:0] delta;
    logic [25:0] sum;

    always_comb begin
        seg_end = {1'b0, off} + {1'b0, len};
        st_end  = {2'b00, so} + {1'b0, sl};
        new_off = (off < so) ? off : so;
        new_end = ({1'b0, seg_end} > st_end) ? {1'b0, seg_end} : st_end;
        span    = new_end - {2'b00, new_off};

        // The length change may be negative when the union span wraps past 17 bits.
        if (merge_sel) begin
            delta = {9'd0, span[16:0]} - {9'd0, sl};
        end else begin
            delta = {10'd0, len};
        end
        sum = {2'b00, total} + delta;

        res.same     = (off == so) && ({1'b0, len} == sl);
        res.right_of = seg_end < {1'b0, so};
        res.left     = {2'b00, off} > st_end;
        res.noff     = new_off;
        res.nlen     = span[16:0];
        res.ovf      = sum[25] || sum[24];
        res.total    = res.ovf ? {ssl_pkg::TOTAL_W{1'b1}} : sum[23:0];
    end

endmodule

// ===== tb/sorted_segment_list_insert_top_tb.sv =====
`timescale 1ns / 1ps

module sorted_segment_list_insert_top_tb;

    localparam int LIST_DEPTH   = 16;
    localparam int TOTAL_CAP    = 24'hFFFFFF;
    localparam int RANDOM_ITEMS = 510;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 20;

    typedef struct packed {
        ssl_pkg::outcome_t outcome;
        logic [4:0]        count;
        logic [23:0]       total;
        logic              ovf;
    } seg_result_t;

    typedef struct packed {
        logic [15:0] off;
        logic [15:0] len;
        logic [7:0]  era;
        logic        typed;
        seg_result_t res;
    } seg_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_seg_offset;
    logic [15:0] s_seg_length;
    logic [7:0]  s_era;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_outcome;
    logic [4:0]  m_seg_count;
    logic [23:0] m_total_length;
    logic        m_overflow;

    logic [15:0]  list_off [LIST_DEPTH];
    logic [16:0]  list_len [LIST_DEPTH];
    int unsigned  held;
    int unsigned  run_total;
    logic [7:0]   cur_era;
    bit           era_valid;

    seg_result_t pending_results [$];
    seg_row_t    plan [$];
    int          errors;
    int          src_idle;
    int          snk_idle;

    sorted_segment_list_insert_top #(
        .MAX_SEGMENTS(LIST_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_seg_offset  (s_seg_offset),
        .s_seg_length  (s_seg_length),
        .s_era         (s_era),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_seg_count   (m_seg_count),
        .m_total_length(m_total_length),
        .m_overflow    (m_overflow)
    );

    always #5 aclk = ~aclk;

    function automatic bit bump_total(input int unsigned amount);
        int unsigned sum;
        sum = run_total + amount;
        if (sum > TOTAL_CAP) begin
            run_total = TOTAL_CAP;
            return 1'b1;
        end
        run_total = sum;
        return 1'b0;
    endfunction

    function automatic seg_result_t predict_insert(input logic [15:0] off_in,
                                                   input logic [15:0] len_in,
                                                   input logic [7:0] era_in);
        int unsigned       off, len, fin, so, sl, se, noff, nend, nlen, pos, k;
        bit                ovf;
        bit                ins;
        ssl_pkg::outcome_t oc;
        seg_result_t       r;
        off = off_in;
        len = len_in;
        fin = off + len;
        oc  = ssl_pkg::OUT_APPEND;
        ovf = 1'b0;
        ins = 1'b1;
        if (!era_valid || era_in != cur_era) begin
            held      = 0;
            run_total = 0;
        end
        era_valid = 1'b1;
        cur_era   = era_in;
        for (pos = 0; pos < held; pos++) begin
            so = list_off[pos];
            sl = list_len[pos];
            se = so + sl;
            if (off == so && len == sl) begin
                oc  = ssl_pkg::OUT_SAME;
                ins = 1'b0;
                break;
            end
            if (fin < so) begin
                oc = ssl_pkg::OUT_BEFORE;
                break;
            end
            if (off > se) continue;
            noff = (off < so) ? off : so;
            nend = (fin > se) ? fin : se;
            nlen = (nend - noff) & 32'h1FFFF;
            ovf  = bump_total(nlen - sl);
            list_off[pos] = noff[15:0];
            list_len[pos] = nlen[16:0];
            oc  = ssl_pkg::OUT_MERGE;
            ins = 1'b0;
            break;
        end
        if (ins) begin
            if (len == 0) begin
                oc = ssl_pkg::OUT_IGNORE;
            end else if (held >= LIST_DEPTH) begin
                oc  = ssl_pkg::OUT_IGNORE;
                ovf = 1'b1;
            end else begin
                for (k = held; k > pos; k--) begin
                    list_off[k] = list_off[k-1];
                    list_len[k] = list_len[k-1];
                end
                list_off[pos] = off[15:0];
                list_len[pos] = len[16:0];
                held++;
                ovf = bump_total(len);
                if (pos == held - 1) begin
                    oc = ssl_pkg::OUT_APPEND;
                end else begin
                    oc = ssl_pkg::OUT_BEFORE;
                end
            end
        end
        r.outcome = oc;
        r.count   = held[4:0];
        r.total   = run_total[23:0];
        r.ovf     = ovf;
        return r;
    endfunction

    task automatic send_request(input logic [15:0] off, input logic [15:0] len,
                                input logic [7:0] era, input logic typed,
                                input seg_result_t typed_res);
        seg_result_t predicted;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_seg_offset <= off;
        s_seg_length <= len;
        s_era        <= era;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_insert(off, len, era);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            pending_results.push_back(predicted);
        end
    endtask

    initial begin
        seg_result_t exp_res;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result outcome=%0d count=%0d total=%0d ovf=%0d",
                             $time, m_outcome, m_seg_count, m_total_length, m_overflow);
                    errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (m_outcome !== exp_res.outcome) begin
                        $display("%0t: outcome expected %0d actual %0d",
                                 $time, exp_res.outcome, m_outcome);
                        errors++;
                    end
                    if (m_seg_count !== exp_res.count) begin
                        $display("%0t: seg_count expected %0d actual %0d",
                                 $time, exp_res.count, m_seg_count);
                        errors++;
                    end
                    if (m_total_length !== exp_res.total) begin
                        $display("%0t: total_length expected %0d actual %0d",
                                 $time, exp_res.total, m_total_length);
                        errors++;
                    end
                    if (m_overflow !== exp_res.ovf) begin
                        $display("%0t: overflow expected %0d actual %0d",
                                 $time, exp_res.ovf, m_overflow);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial begin
        #5ms;
        $display("sorted_segment_list_insert_top regression: fail");
        $finish;
    end

    initial begin
        int          i;
        logic [15:0] off;
        logic [15:0] len;
        logic [7:0]  era;
        logic [15:0] last_off;
        logic [15:0] last_len;
        int unsigned base;
        seg_row_t    row;
        seg_result_t none;

        none         = '0;
        errors       = 0;
        held         = 0;
        run_total    = 0;
        cur_era      = '0;
        era_valid    = 1'b0;
        src_idle     = 7;
        snk_idle     = 65;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_seg_offset <= '0;
        s_seg_length <= '0;
        s_era        <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back('{16'd100, 16'd10, 8'h00, 1'b1,
                         '{ssl_pkg::OUT_APPEND, 5'd1, 24'd10, 1'b0}});
        plan.push_back('{16'd100, 16'd10, 8'h00, 1'b1,
                         '{ssl_pkg::OUT_SAME, 5'd1, 24'd10, 1'b0}});
        plan.push_back('{16'd500, 16'd0, 8'h00, 1'b1,
                         '{ssl_pkg::OUT_IGNORE, 5'd1, 24'd10, 1'b0}});
        plan.push_back('{16'd50, 16'd10, 8'h00, 1'b1,
                         '{ssl_pkg::OUT_BEFORE, 5'd2, 24'd20, 1'b0}});
        plan.push_back('{16'd60, 16'd40, 8'h00, 1'b0, none});
        plan.push_back('{16'd55, 16'd0, 8'h00, 1'b0, none});
        plan.push_back('{16'h0000, 16'hFFFF, 8'h05, 1'b1,
                         '{ssl_pkg::OUT_APPEND, 5'd1, 24'd65535, 1'b0}});
        plan.push_back('{16'hFFFF, 16'hFFFF, 8'h05, 1'b0, none});
        plan.push_back('{16'h0000, 16'h0000, 8'hFF, 1'b1,
                         '{ssl_pkg::OUT_IGNORE, 5'd0, 24'd0, 1'b0}});
        for (i = 0; i < LIST_DEPTH; i++) begin
            plan.push_back('{16'((LIST_DEPTH - 1 - i) * 200), 16'd10, 8'hAA, 1'b0, none});
        end
        plan.push_back('{16'd4000, 16'd10, 8'hAA, 1'b1,
                         '{ssl_pkg::OUT_IGNORE, 5'd16, 24'd160, 1'b1}});
        plan.push_back('{16'd3005, 16'd20, 8'hAA, 1'b0, none});

        foreach (plan[j]) begin
            row = plan[j];
            send_request(row.off, row.len, row.era, row.typed, row.res);
        end

        era      = 8'hAA;
        base     = 3000;
        last_off = 16'd3005;
        last_len = 16'd20;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                src_idle = 65;
                snk_idle = 7;
            end
            if (i == 2 * RANDOM_ITEMS / 3) begin
                src_idle = 0;
                snk_idle = 0;
            end
            if ($urandom_range(0, 39) == 0) begin
                era  = 8'($urandom_range(0, 255));
                base = $urandom_range(0, 65535);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    off = 16'(base + $urandom_range(0, 2000));
                    len = 16'($urandom_range(1, 300));
                end
                6: begin
                    off = last_off;
                    len = last_len;
                end
                7: begin
                    off = 16'(base + $urandom_range(0, 2500));
                    len = 16'd0;
                end
                8: begin
                    off = 16'($urandom);
                    len = 16'($urandom);
                end
                default: begin
                    off = 16'($urandom);
                    len = 16'($urandom_range(0, 64));
                end
            endcase
            send_request(off, len, era, 1'b0, none);
            last_off = off;
            last_len = len;
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("sorted_segment_list_insert_top regression: pass");
        end else begin
            $display("sorted_segment_list_insert_top regression: fail");
        end
        $finish;
    end

endmodule
